/* rtl/core/bph_pkg.sv */
// bph_pkg: types, constants and helpers shared by the byte pattern hunter
// no dependencies; used by bph_scan, bph_out_queue and byte_pattern_hunter
`default_nettype none

package bph_pkg;

  localparam int unsigned BPH_PATTERN_MAX = 8;
  localparam int unsigned BPH_HITS_MAX    = 16;
  localparam int unsigned BPH_QUEUE_DEPTH = 4;

  localparam int unsigned ADDR_W    = 28;
  localparam int unsigned PATTERN_W = 64;
  localparam int unsigned PLEN_W    = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       present;
    logic       start_ok;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] hit_address;
    logic [COUNT_W-1:0] hit_count;
    logic              truncated;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic hit;
    logic summary;
  } push_t;

  // pattern byte k, zero beyond the eighth byte
  function automatic logic [7:0] pattern_byte(logic [PATTERN_W-1:0] pat, logic [4:0] k);
    logic [7:0] b;
    b = 8'h00;
    if (k < 5'd8) begin
      b = pat[{k[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/byte_pattern_hunter.sv */
// byte_pattern_hunter: top level, config registers, input register and glue
// depends on bph_pkg, bph_scan and bph_out_queue
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  data_byte, present, start_ok, last_byte
//   out      output     out_valid_o/out_stall_i kind, hit_address, hit_count, truncated,
//                                              last_result
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one byte per cycle while the result queue has room; an accepted transaction is held in
// the input register, compared there, then written into the result queue and offered out
// a byte that yields a hit and a summary puts both into the queue in the same cycle
// the input stalls only while the four-entry result queue has fewer than two free slots
// reset clears the window, counters and queue; config resets to start 0, pattern 0, length 1
`default_nettype none

module byte_pattern_hunter #(
  parameter int unsigned PATTERN_MAX = bph_pkg::BPH_PATTERN_MAX,
  parameter int unsigned HIT_CAP     = bph_pkg::BPH_HITS_MAX
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      data_byte_i,
  input  wire logic                            present_i,
  input  wire logic                            start_ok_i,
  input  wire logic                            last_byte_i,

  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 kind_o,
  output logic [bph_pkg::ADDR_W-1:0]           hit_address_o,
  output logic [bph_pkg::COUNT_W-1:0]          hit_count_o,
  output logic                                 truncated_o,
  output logic                                 last_result_o,

  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bph_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bph_pkg::PATTERN_W-1:0]   cfg_data_i
);

  logic [bph_pkg::ADDR_W-1:0]    start_address_q;
  logic [bph_pkg::PATTERN_W-1:0] pattern_q;
  logic [bph_pkg::PLEN_W-1:0]    pattern_length_q;

  bph_pkg::item_t   item_q;
  logic             item_vld_q;
  logic             accept, proc, room;
  bph_pkg::push_t   push;
  bph_pkg::result_t hit_res, sum_res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_address_q  <= '0;
      pattern_q        <= '0;
      pattern_length_q <= bph_pkg::PLEN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bph_pkg::CFG_START_ADDRESS:  start_address_q  <= cfg_data_i[bph_pkg::ADDR_W-1:0];
        bph_pkg::CFG_PATTERN:        pattern_q        <= cfg_data_i;
        bph_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[bph_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign proc       = item_vld_q && room;
  assign in_stall_o = item_vld_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (accept) begin
      item_vld_q <= 1'b1;
    end else if (proc) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte <= data_byte_i;
      item_q.present   <= present_i;
      item_q.start_ok  <= start_ok_i;
      item_q.last_byte <= last_byte_i;
    end
  end

  bph_scan #(
    .PATTERN_MAX (PATTERN_MAX),
    .HIT_CAP     (HIT_CAP)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .proc_i           (proc),
    .item_i           (item_q),
    .start_address_i  (start_address_q),
    .pattern_i        (pattern_q),
    .pattern_length_i (pattern_length_q),
    .push_o           (push),
    .hit_res_o        (hit_res),
    .sum_res_o        (sum_res)
  );

  bph_out_queue #(
    .DEPTH (bph_pkg::BPH_QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .hit_res_i   (hit_res),
    .sum_res_i   (sum_res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign kind_o        = out_res.kind;
  assign hit_address_o = out_res.hit_address;
  assign hit_count_o   = out_res.hit_count;
  assign truncated_o   = out_res.truncated;
  assign last_result_o = out_res.last_result;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_vld_q && !room))
    else $error("input stalled with room in the queue");

endmodule

`default_nettype wire

/* rtl/core/bph_scan.sv */
// bph_scan: byte window, match compare and stream counters
// depends on bph_pkg
`default_nettype none

module bph_scan #(
  parameter int unsigned PATTERN_MAX = bph_pkg::BPH_PATTERN_MAX,
  parameter int unsigned HIT_CAP     = bph_pkg::BPH_HITS_MAX
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            proc_i,
  input  wire bph_pkg::item_t                  item_i,
  input  wire logic [bph_pkg::ADDR_W-1:0]      start_address_i,
  input  wire logic [bph_pkg::PATTERN_W-1:0]   pattern_i,
  input  wire logic [bph_pkg::PLEN_W-1:0]      pattern_length_i,
  output bph_pkg::push_t                       push_o,
  output bph_pkg::result_t                     hit_res_o,
  output bph_pkg::result_t                     sum_res_o
);

  localparam int unsigned IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned CNT_RAW = $clog2(HIT_CAP + 1);
  localparam int unsigned CNT_W   = (CNT_RAW < bph_pkg::COUNT_W) ? bph_pkg::COUNT_W : CNT_RAW;

  logic [7:0]                  bytes_q [PATTERN_MAX];
  logic [7:0]                  bytes_d [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]      pres_q, pres_d, strt_q, strt_d;
  logic [bph_pkg::ADDR_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]            hits_q, hits_d, hits_inc, hits_after;
  logic                        later_q, later_d, later_after;

  logic [4:0]                  len_m1;
  logic [IDX_W-1:0]            cand_idx;
  logic                        cand, at_cap, match, hit;

  always_comb begin
    len_m1 = 5'd0;
    if (pattern_length_i == '0) begin
      len_m1 = 5'd0;
    end else if ({1'b0, pattern_length_i} > 5'(PATTERN_MAX)) begin
      len_m1 = 5'(PATTERN_MAX - 1);
    end else begin
      len_m1 = {1'b0, pattern_length_i} - 5'd1;
    end
  end

  assign cand_idx = len_m1[IDX_W-1:0];

  // shifted window with the new byte in slot zero
  always_comb begin
    bytes_d[0] = item_i.data_byte;
    pres_d[0]  = item_i.present;
    strt_d[0]  = item_i.start_ok;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      bytes_d[i] = bytes_q[i-1];
      pres_d[i]  = pres_q[i-1];
      strt_d[i]  = strt_q[i-1];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int w = 0; w < PATTERN_MAX; w++) begin
      if (5'(w) <= len_m1) begin
        if (!pres_d[w] || (bytes_d[w] != bph_pkg::pattern_byte(pattern_i, len_m1 - 5'(w)))) begin
          match = 1'b0;
        end
      end
    end
  end

  assign cand        = strt_d[cand_idx];
  assign at_cap      = (hits_q >= CNT_W'(HIT_CAP));
  assign hit         = cand && !at_cap && match;
  assign hits_inc    = hits_q + CNT_W'(1);
  assign hits_after  = hit ? hits_inc : hits_q;
  assign later_after = later_q | (cand & at_cap);

  assign push_o.hit     = proc_i && hit;
  assign push_o.summary = proc_i && item_i.last_byte;

  always_comb begin
    hit_res_o.kind        = bph_pkg::KIND_HIT;
    hit_res_o.hit_address = start_address_i + pos_q - bph_pkg::ADDR_W'(len_m1);
    hit_res_o.hit_count   = hits_inc[bph_pkg::COUNT_W-1:0];
    hit_res_o.truncated   = 1'b0;
    hit_res_o.last_result = !item_i.last_byte;

    sum_res_o.kind        = bph_pkg::KIND_SUMMARY;
    sum_res_o.hit_address = '0;
    sum_res_o.hit_count   = hits_after[bph_pkg::COUNT_W-1:0];
    sum_res_o.truncated   = (hits_after >= CNT_W'(HIT_CAP)) && later_after;
    sum_res_o.last_result = 1'b1;
  end

  always_comb begin
    pos_d   = pos_q + bph_pkg::ADDR_W'(1);
    hits_d  = hits_after;
    later_d = later_after;
    if (item_i.last_byte) begin
      pos_d   = '0;
      hits_d  = '0;
      later_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q  <= '0;
      strt_q  <= '0;
      pos_q   <= '0;
      hits_q  <= '0;
      later_q <= 1'b0;
    end else if (proc_i) begin
      pos_q   <= pos_d;
      hits_q  <= hits_d;
      later_q <= later_d;
      if (item_i.last_byte) begin
        pres_q <= '0;
        strt_q <= '0;
      end else begin
        pres_q <= pres_d;
        strt_q <= strt_d;
      end
    end
  end

  // bytes are only looked at while their present flag is set
  always_ff @(posedge clk_i) begin
    if (proc_i) begin
      bytes_q <= bytes_d;
    end
  end

  a_hit_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.hit |-> (hits_q < CNT_W'(HIT_CAP)))
    else $error("hit reported with cap reached");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_i && item_i.last_byte) |=> (hits_q == '0) && (pres_q == '0) && !later_q)
    else $error("stream state not cleared after last byte");

endmodule

`default_nettype wire

/* rtl/core/bph_out_queue.sv */
// bph_out_queue: small result queue taking up to two results per cycle
// depends on bph_pkg
`default_nettype none

module bph_out_queue #(
  parameter int unsigned DEPTH = bph_pkg::BPH_QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bph_pkg::push_t    push_i,
  input  wire bph_pkg::result_t  hit_res_i,
  input  wire bph_pkg::result_t  sum_res_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bph_pkg::result_t       out_res_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bph_pkg::result_t   entries_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;
  logic [1:0]         n_push;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_q <= CNT_W'(DEPTH - 2));
  assign out_res_o   = entries_q[rd_q];
  assign n_push      = {1'b0, push_i.hit} + {1'b0, push_i.summary};
  assign wr_next     = wr_q + PTR_W'(1);

  always_comb begin
    wr_d    = wr_q + PTR_W'(n_push);
    rd_d    = rd_q + PTR_W'(pop);
    count_d = count_q + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // hit goes first, summary behind it
  always_ff @(posedge clk_i) begin
    if (push_i.hit) begin
      entries_q[wr_q] <= hit_res_i;
      if (push_i.summary) begin
        entries_q[wr_next] <= sum_res_i;
      end
    end else if (push_i.summary) begin
      entries_q[wr_q] <= sum_res_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.hit || push_i.summary) |-> room_o)
    else $error("push without room");

endmodule

`default_nettype wire
